// ----- src/cau_pkg.sv -----
// shared constants, types and helper functions of the complex arithmetic unit
// depends on nothing; imported by complex_arithmetic_unit
`default_nettype none
package cau_pkg;

   localparam int W   = 32;
   localparam int F   = 16;
   localparam int PW  = 2 * W;
   localparam int SW  = PW + 1;
   localparam int WD  = SW + 1;
   localparam int QB  = W + 2;
   localparam int DSH = F + 1;
   localparam int OVS = QB - DSH;
   localparam int R1  = W + 1;
   localparam int X1  = 2 * R1;
   localparam int VW  = W + 2;
   localparam int R2  = (VW + DSH + 1) / 2;
   localparam int X2  = 2 * R2;

   typedef logic [2:0] op_type;
   localparam op_type OP_ADD  = 3'd0;
   localparam op_type OP_SUB  = 3'd1;
   localparam op_type OP_MUL  = 3'd2;
   localparam op_type OP_DIV  = 3'd3;
   localparam op_type OP_MAG  = 3'd4;
   localparam op_type OP_SQRT = 3'd5;

   typedef logic [1:0] status_type;
   localparam status_type ST_OK  = 2'd0;
   localparam status_type ST_DZ  = 2'd1;
   localparam status_type ST_OVF = 2'd2;

   localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

   typedef logic [WD-1:0] wide_type;

   typedef struct packed {
      op_type           op;
      logic [W-1:0]     a_re;
      logic             a_im_neg;
      logic [W-1:0]     fin_re;
      logic [W-1:0]     fin_im;
      status_type       st;
   } carry_type;

   typedef struct packed {
      carry_type  c;
      logic       dz;
      logic [1:0] neg;
      logic [1:0] nz;
      logic [1:0] dovf;
   } side_type;

   function automatic wide_type abs_w(input wide_type v);
      wide_type r;
      r = v[WD-1] ? (~v + 1'b1) : v;
      return r;
   endfunction

   // returns {overflow, saturated two's complement word}
   function automatic logic [W:0] sat_sm(input logic neg, input wide_type mag);
      wide_type     lim;
      logic [W-1:0] m;
      logic [W-1:0] v;
      logic         ovf;
      lim = neg ? (wide_type'(1) << (W-1)) : ((wide_type'(1) << (W-1)) - 1'b1);
      if (mag > lim) begin
         m   = lim[W-1:0];
         ovf = 1'b1;
      end else begin
         m   = mag[W-1:0];
         ovf = 1'b0;
      end
      v = neg ? (~m + 1'b1) : m;
      return {ovf, v};
   endfunction

endpackage
`default_nettype wire

// ----- src/complex_arithmetic_unit.sv -----
// complex arithmetic unit: add, sub, mul, div, magnitude, square root on Q16.16
// pipelined datapath with restoring divider and bit-serial root stages
// depends on cau_pkg
//
// usage:
//   requests enter on req_valid/req_ready with an opcode and two complex
//   operands; each request yields exactly one response on rsp_valid/rsp_ready
//   carrying res_re, res_im and a status (ok, divide by zero, overflow).
//   every opcode passes the same stages: multiply and sum, division with
//   one quotient bit per stage beside the 33 stages of the magnitude root,
//   rounding, 26 stages of the half-angle roots and the output register.
//   the whole pipe advances together; throughput is one request per cycle
//   while rsp_ready does not stall a pending response.
//   when the receiver holds rsp_ready low with a response pending, every
//   stage holds and req_ready drops; nothing is lost or repeated.
//   reset clears all stage valid bits; payload registers are not reset.
//   opcodes 6 and 7 return zero with status ok.
`default_nettype none
module complex_arithmetic_unit (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [2:0]                   req_opcode,
   input  wire logic signed [cau_pkg::W-1:0] req_a_re,
   input  wire logic signed [cau_pkg::W-1:0] req_a_im,
   input  wire logic signed [cau_pkg::W-1:0] req_b_re,
   input  wire logic signed [cau_pkg::W-1:0] req_b_im,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic signed [cau_pkg::W-1:0]      rsp_res_re,
   output logic signed [cau_pkg::W-1:0]      rsp_res_im,
   output logic [1:0]                        rsp_status
);
   import cau_pkg::*;

   localparam int P_RR = 0;
   localparam int P_II = 1;
   localparam int P_RI = 2;
   localparam int P_IR = 3;
   localparam int P_XX = 4;
   localparam int P_YY = 5;

   logic ce;

   // stage 1
   logic                 s1_v_ff;
   carry_type            s1_c_ff, s1_c_in;
   logic signed [PW-1:0] s1_p_ff [0:5];
   logic signed [PW-1:0] s1_p_in [0:5];

   // stage 2
   logic                 s2_v_ff;
   carry_type            s2_c_ff;
   logic signed [SW-1:0] s2_mre_ff, s2_mim_ff, s2_nre_ff, s2_nim_ff;
   logic signed [SW-1:0] s2_mre_in, s2_mim_in, s2_nre_in, s2_nim_in;
   logic [PW-1:0]        s2_dsq_ff, s2_dsq_in;

   // divide and magnitude root stages
   logic          it_v_ff   [0:QB];
   side_type      it_s_ff   [0:QB];
   side_type      it_s_in   [0:QB];
   logic [PW-1:0] it_d_ff   [0:QB];
   logic [PW-1:0] it_d_in   [0:QB];
   logic [PW-1:0] it_rem_ff [0:1][0:QB];
   logic [PW-1:0] it_rem_in [0:1][0:QB];
   logic [QB-1:0] it_lo_ff  [0:1][0:QB];
   logic [QB-1:0] it_lo_in  [0:1][0:QB];
   logic [QB-1:0] it_q_ff   [0:1][0:QB];
   logic [QB-1:0] it_q_in   [0:1][0:QB];
   logic [X1-1:0] it_x_ff   [0:QB];
   logic [X1-1:0] it_x_in   [0:QB];
   logic [R1+1:0] it_r1_ff  [0:QB];
   logic [R1+1:0] it_r1_in  [0:QB];
   logic [R1-1:0] it_rt_ff  [0:QB];
   logic [R1-1:0] it_rt_in  [0:QB];

   // half-angle root stages
   logic          sq_v_ff    [0:R2];
   carry_type     sq_c_ff    [0:R2];
   carry_type     sq_c_in    [0:R2];
   logic [X2-1:0] sq_x_ff    [0:1][0:R2];
   logic [X2-1:0] sq_x_in    [0:1][0:R2];
   logic [R2+1:0] sq_rem_ff  [0:1][0:R2];
   logic [R2+1:0] sq_rem_in  [0:1][0:R2];
   logic [R2-1:0] sq_rt_ff   [0:1][0:R2];
   logic [R2-1:0] sq_rt_in   [0:1][0:R2];

   // output register
   logic          rsp_valid_ff;
   logic [W-1:0]  rsp_re_ff, rsp_re_in;
   logic [W-1:0]  rsp_im_ff, rsp_im_in;
   status_type    rsp_st_ff, rsp_st_in;
   op_type        out_op_ff;

   assign ce        = !rsp_valid_ff || rsp_ready;
   assign req_ready = ce;

   // stage 1: add/sub done here, products for everything else
   always_comb begin
      logic signed [W:0] sr;
      logic signed [W:0] si;
      logic [W:0]        ovr;
      logic [W:0]        ovi;
      s1_c_in          = '0;
      s1_c_in.op       = req_opcode;
      s1_c_in.a_re     = req_a_re;
      s1_c_in.a_im_neg = req_a_im[W-1];
      s1_c_in.st       = ST_OK;
      if (req_opcode == OP_SUB) begin
         sr = req_a_re - req_b_re;
         si = req_a_im - req_b_im;
      end else begin
         sr = req_a_re + req_b_re;
         si = req_a_im + req_b_im;
      end
      ovr = sat_sm(sr[W], abs_w({{(WD-W-1){sr[W]}}, sr}));
      ovi = sat_sm(si[W], abs_w({{(WD-W-1){si[W]}}, si}));
      if (req_opcode == OP_ADD || req_opcode == OP_SUB) begin
         s1_c_in.fin_re = ovr[W-1:0];
         s1_c_in.fin_im = ovi[W-1:0];
         s1_c_in.st     = (ovr[W] || ovi[W]) ? ST_OVF : ST_OK;
      end
      s1_p_in[P_RR] = req_a_re * req_b_re;
      s1_p_in[P_II] = req_a_im * req_b_im;
      s1_p_in[P_RI] = req_a_re * req_b_im;
      s1_p_in[P_IR] = req_a_im * req_b_re;
      if (req_opcode == OP_DIV) begin
         s1_p_in[P_XX] = req_b_re * req_b_re;
         s1_p_in[P_YY] = req_b_im * req_b_im;
      end else begin
         s1_p_in[P_XX] = req_a_re * req_a_re;
         s1_p_in[P_YY] = req_a_im * req_a_im;
      end
   end

   // stage 2: cross sums and sum of squares
   always_comb begin
      logic signed [SW-1:0] dsum;
      s2_mre_in = SW'(s1_p_ff[P_RR]) - SW'(s1_p_ff[P_II]);
      s2_mim_in = SW'(s1_p_ff[P_RI]) + SW'(s1_p_ff[P_IR]);
      s2_nre_in = SW'(s1_p_ff[P_RR]) + SW'(s1_p_ff[P_II]);
      s2_nim_in = SW'(s1_p_ff[P_IR]) - SW'(s1_p_ff[P_RI]);
      dsum      = SW'(s1_p_ff[P_XX]) + SW'(s1_p_ff[P_YY]);
      s2_dsq_in = dsum[PW-1:0];
   end

   // stage 3: multiply rounding, divider and root setup
   always_comb begin
      wide_type        mag_r, mag_i, rnd_r, rnd_i, nm_w;
      logic [W:0]      sat_r, sat_i;
      logic [PW-1:0]   nm;
      logic [PW+OVS-1:0] dshift;
      logic signed [SW-1:0] num [0:1];
      logic [PW:0]   r2;
      logic [PW:0]   df;
      logic          ge;
      logic [R1+3:0] remw;
      logic [R1+3:0] trial;
      logic [R1+3:0] rdiff;
      logic          ge1;
      it_s_in[0]      = '0;
      it_s_in[0].c    = s2_c_ff;
      mag_r = abs_w({s2_mre_ff[SW-1], s2_mre_ff});
      mag_i = abs_w({s2_mim_ff[SW-1], s2_mim_ff});
      rnd_r = (mag_r + (wide_type'(1) << (F-1))) >> F;
      rnd_i = (mag_i + (wide_type'(1) << (F-1))) >> F;
      sat_r = sat_sm(s2_mre_ff[SW-1], rnd_r);
      sat_i = sat_sm(s2_mim_ff[SW-1], rnd_i);
      if (s2_c_ff.op == OP_MUL) begin
         it_s_in[0].c.fin_re = sat_r[W-1:0];
         it_s_in[0].c.fin_im = sat_i[W-1:0];
         it_s_in[0].c.st     = (sat_r[W] || sat_i[W]) ? ST_OVF : ST_OK;
      end
      it_s_in[0].dz = (s2_dsq_ff == '0);
      it_d_in[0]    = s2_dsq_ff;
      dshift        = {s2_dsq_ff, {OVS{1'b0}}};
      num[0]        = s2_nre_ff;
      num[1]        = s2_nim_ff;
      for (int l = 0; l < 2; l++) begin
         nm_w                  = abs_w({num[l][SW-1], num[l]});
         nm                    = nm_w[PW-1:0];
         it_s_in[0].neg[l]     = num[l][SW-1];
         it_s_in[0].nz[l]      = (nm != '0);
         it_s_in[0].dovf[l]    = ({{OVS{1'b0}}, nm} >= dshift);
         it_rem_in[l][0]       = nm >> OVS;
         it_lo_in[l][0]        = {nm[OVS-1:0], {DSH{1'b0}}};
         it_q_in[l][0]         = '0;
      end
      it_x_in[0]  = {s2_dsq_ff, 2'b00};
      it_r1_in[0] = '0;
      it_rt_in[0] = '0;
      // one quotient bit per stage in both lanes, one root bit per stage
      for (int k = 0; k < QB; k++) begin
         it_s_in[k+1] = it_s_ff[k];
         it_d_in[k+1] = it_d_ff[k];
         for (int l = 0; l < 2; l++) begin
            r2 = {it_rem_ff[l][k], it_lo_ff[l][k][QB-1]};
            df = r2 - {1'b0, it_d_ff[k]};
            ge = (r2 >= {1'b0, it_d_ff[k]});
            it_rem_in[l][k+1] = ge ? df[PW-1:0] : r2[PW-1:0];
            it_lo_in[l][k+1]  = {it_lo_ff[l][k][QB-2:0], 1'b0};
            it_q_in[l][k+1]   = {it_q_ff[l][k][QB-2:0], ge};
         end
         if (k < R1) begin
            remw  = {it_r1_ff[k], it_x_ff[k][X1-1:X1-2]};
            trial = (R1+4)'({it_rt_ff[k], 2'b01});
            rdiff = remw - trial;
            ge1   = (remw >= trial);
            it_r1_in[k+1] = ge1 ? rdiff[R1+1:0] : remw[R1+1:0];
            it_rt_in[k+1] = {it_rt_ff[k][R1-2:0], ge1};
            it_x_in[k+1]  = {it_x_ff[k][X1-3:0], 2'b00};
         end else begin
            it_r1_in[k+1] = it_r1_ff[k];
            it_rt_in[k+1] = it_rt_ff[k];
            it_x_in[k+1]  = it_x_ff[k];
         end
      end
   end

   // rounding of magnitude and quotients, setup of the half-angle roots
   always_comb begin
      side_type        sd;
      logic [R1:0]     mt;
      logic [R1-1:0]   m;
      logic [W:0]      msat;
      logic [QB:0]     qt;
      logic [QB-1:0]   qr;
      logic [W:0]      qs;
      logic [W-1:0]    val [0:1];
      logic [1:0]      ovf;
      logic [VW:0]     v_re, v_im;
      logic [R2+3:0]   remw;
      logic [R2+3:0]   trial;
      logic [R2+3:0]   rdiff;
      logic            ge;
      sd   = it_s_ff[QB];
      mt   = {1'b0, it_rt_ff[QB]} + 1'b1;
      m    = mt[R1:1];
      msat = sat_sm(1'b0, wide_type'(m));
      for (int l = 0; l < 2; l++) begin
         qt = {1'b0, it_q_ff[l][QB]} + 1'b1;
         qr = qt[QB:1];
         qs = sat_sm(sd.neg[l], wide_type'(qr));
         if (sd.dz) begin
            val[l] = sd.nz[l] ? (sd.neg[l] ? MINV : MAXV) : '0;
            ovf[l] = 1'b0;
         end else if (sd.dovf[l]) begin
            val[l] = sd.neg[l] ? MINV : MAXV;
            ovf[l] = 1'b1;
         end else begin
            val[l] = qs[W-1:0];
            ovf[l] = qs[W];
         end
      end
      sq_c_in[0] = sd.c;
      unique case (sd.c.op)
         OP_DIV: begin
            sq_c_in[0].fin_re = val[0];
            sq_c_in[0].fin_im = val[1];
            sq_c_in[0].st     = sd.dz ? ST_DZ : ((ovf != 2'b00) ? ST_OVF : ST_OK);
         end
         OP_MAG: begin
            sq_c_in[0].fin_re = msat[W-1:0];
            sq_c_in[0].fin_im = '0;
            sq_c_in[0].st     = msat[W] ? ST_OVF : ST_OK;
         end
         default: begin
         end
      endcase
      v_re = (VW+1)'(m) + {{(VW+1-W){sd.c.a_re[W-1]}}, sd.c.a_re};
      v_im = (VW+1)'(m) - {{(VW+1-W){sd.c.a_re[W-1]}}, sd.c.a_re};
      sq_x_in[0][0]   = X2'({v_re[VW-1:0], {DSH{1'b0}}});
      sq_x_in[1][0]   = X2'({v_im[VW-1:0], {DSH{1'b0}}});
      sq_rem_in[0][0] = '0;
      sq_rem_in[1][0] = '0;
      sq_rt_in[0][0]  = '0;
      sq_rt_in[1][0]  = '0;
      // half-angle roots, one bit per stage in two lanes
      for (int k = 0; k < R2; k++) begin
         sq_c_in[k+1] = sq_c_ff[k];
         for (int l = 0; l < 2; l++) begin
            remw  = {sq_rem_ff[l][k], sq_x_ff[l][k][X2-1:X2-2]};
            trial = (R2+4)'({sq_rt_ff[l][k], 2'b01});
            rdiff = remw - trial;
            ge    = (remw >= trial);
            sq_rem_in[l][k+1] = ge ? rdiff[R2+1:0] : remw[R2+1:0];
            sq_rt_in[l][k+1]  = {sq_rt_ff[l][k][R2-2:0], ge};
            sq_x_in[l][k+1]   = {sq_x_ff[l][k][X2-3:0], 2'b00};
         end
      end
   end

   // result select
   always_comb begin
      carry_type   cf;
      logic [R2:0] t_re, t_im;
      logic [W-1:0] rr, ri;
      cf   = sq_c_ff[R2];
      t_re = {1'b0, sq_rt_ff[0][R2]} + 1'b1;
      t_im = {1'b0, sq_rt_ff[1][R2]} + 1'b1;
      rr   = W'(t_re[R2:1]);
      ri   = W'(t_im[R2:1]);
      rsp_re_in = cf.fin_re;
      rsp_im_in = cf.fin_im;
      rsp_st_in = cf.st;
      if (cf.op == OP_SQRT) begin
         rsp_re_in = rr;
         rsp_im_in = cf.a_im_neg ? (~ri + 1'b1) : ri;
         rsp_st_in = ST_OK;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= QB; k++) it_v_ff[k] <= 1'b0;
         for (int k = 0; k <= R2; k++) sq_v_ff[k] <= 1'b0;
      end else if (ce) begin
         s1_v_ff    <= req_valid;
         s2_v_ff    <= s1_v_ff;
         it_v_ff[0] <= s2_v_ff;
         for (int k = 0; k < QB; k++) it_v_ff[k+1] <= it_v_ff[k];
         sq_v_ff[0] <= it_v_ff[QB];
         for (int k = 0; k < R2; k++) sq_v_ff[k+1] <= sq_v_ff[k];
         rsp_valid_ff <= sq_v_ff[R2];
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (ce) begin
         s1_c_ff   <= s1_c_in;
         for (int p = 0; p < 6; p++) s1_p_ff[p] <= s1_p_in[p];
         s2_c_ff   <= s1_c_ff;
         s2_mre_ff <= s2_mre_in;
         s2_mim_ff <= s2_mim_in;
         s2_nre_ff <= s2_nre_in;
         s2_nim_ff <= s2_nim_in;
         s2_dsq_ff <= s2_dsq_in;
         for (int k = 0; k <= QB; k++) begin
            it_s_ff[k]  <= it_s_in[k];
            it_d_ff[k]  <= it_d_in[k];
            it_x_ff[k]  <= it_x_in[k];
            it_r1_ff[k] <= it_r1_in[k];
            it_rt_ff[k] <= it_rt_in[k];
            for (int l = 0; l < 2; l++) begin
               it_rem_ff[l][k] <= it_rem_in[l][k];
               it_lo_ff[l][k]  <= it_lo_in[l][k];
               it_q_ff[l][k]   <= it_q_in[l][k];
            end
         end
         for (int k = 0; k <= R2; k++) begin
            sq_c_ff[k] <= sq_c_in[k];
            for (int l = 0; l < 2; l++) begin
               sq_x_ff[l][k]   <= sq_x_in[l][k];
               sq_rem_ff[l][k] <= sq_rem_in[l][k];
               sq_rt_ff[l][k]  <= sq_rt_in[l][k];
            end
         end
         rsp_re_ff <= rsp_re_in;
         rsp_im_ff <= rsp_im_in;
         rsp_st_ff <= rsp_st_in;
         out_op_ff <= sq_c_ff[R2].op;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res_re = rsp_re_ff;
   assign rsp_res_im = rsp_im_ff;
   assign rsp_status = rsp_st_ff;

   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_v_ff)
      else $error("accepted request missing from first stage");

   a_dz_div: assert property (@(posedge clock) disable iff (reset)
      (sq_v_ff[0] && sq_c_ff[0].st == ST_DZ) |-> (sq_c_ff[0].op == OP_DIV))
      else $error("divide by zero status on a non-divide request");

   a_sqrt_re: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_op_ff == OP_SQRT) |-> !rsp_res_re[W-1])
      else $error("square root with negative real part");

   a_mag_im: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && out_op_ff == OP_MAG) |-> (rsp_res_im == '0))
      else $error("magnitude with nonzero imaginary part");

endmodule
`default_nettype wire

// ----- dv/complex_arithmetic_unit_tb.sv -----
// self-checking testbench for complex_arithmetic_unit: directed and random requests
// checked field by field against a wide-integer model of the Q16.16 datapath
// depends on cau_pkg and complex_arithmetic_unit
`timescale 1ns / 1ps
module complex_arithmetic_unit_tb;
   import cau_pkg::*;

   typedef logic signed [199:0] big_type;
   typedef logic [199:0]        ubig_type;

   typedef struct {
      op_type              op;
      logic signed [W-1:0] a_re;
      logic signed [W-1:0] a_im;
      logic signed [W-1:0] b_re;
      logic signed [W-1:0] b_im;
   } request_type;

   typedef struct {
      logic [W-1:0] re;
      logic [W-1:0] im;
      status_type   st;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [2:0]          req_opcode = '0;
   logic signed [W-1:0] req_a_re = '0;
   logic signed [W-1:0] req_a_im = '0;
   logic signed [W-1:0] req_b_re = '0;
   logic signed [W-1:0] req_b_im = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic signed [W-1:0] rsp_res_re;
   logic signed [W-1:0] rsp_res_im;
   logic [1:0]          rsp_status;

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   int       accepted_count = 0;
   int       answer_count = 0;
   int       mismatch_count = 0;
   int       op_count[8];
   int       dz_count = 0;
   int       ovf_count = 0;
   bit       req_taken = 1'b0;
   bit       stimulus_done = 1'b0;

   complex_arithmetic_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_opcode(req_opcode),
      .req_a_re(req_a_re), .req_a_im(req_a_im), .req_b_re(req_b_re), .req_b_im(req_b_im),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_res_re(rsp_res_re),
      .rsp_res_im(rsp_res_im), .rsp_status(rsp_status)
   );

   always #6 clock = ~clock;

   function automatic ubig_type int_sqrt(ubig_type x);
      ubig_type r;
      ubig_type t;
      r = '0;
      for (int i = 99; i >= 0; i--) begin
         t = r | (ubig_type'(1) << i);
         if (t * t <= x) r = t;
      end
      return r;
   endfunction

   function automatic ubig_type half_round(ubig_type s);
      return (s + 1) >> 1;
   endfunction

   function automatic ubig_type magnitude(big_type re, big_type im);
      return half_round(int_sqrt(ubig_type'(re * re + im * im) << 2));
   endfunction

   function automatic big_type product_round(big_type v);
      ubig_type m;
      m = v < 0 ? ubig_type'(-v) : ubig_type'(v);
      m = (m + (ubig_type'(1) << (F - 1))) >> F;
      return v < 0 ? -big_type'(m) : big_type'(m);
   endfunction

   function automatic big_type quotient_round(big_type n, ubig_type d);
      ubig_type m;
      m = n < 0 ? ubig_type'(-n) : ubig_type'(n);
      m = half_round((m << (F + 1)) / d);
      return n < 0 ? -big_type'(m) : big_type'(m);
   endfunction

   function automatic big_type zero_divide_limit(big_type n);
      if (n > 0) return big_type'(1) << 100;
      if (n < 0) return -(big_type'(1) << 100);
      return '0;
   endfunction

   function automatic logic [W-1:0] clamp_word(big_type v, inout logic ovf);
      if (v > big_type'(MAXV)) begin
         ovf = 1'b1;
         return MAXV;
      end
      if (v < -(big_type'(1) << (W - 1))) begin
         ovf = 1'b1;
         return MINV;
      end
      return v[W-1:0];
   endfunction

   function automatic answer_type compute_complex(request_type q);
      big_type    ar, ai, br, bi, re, im, nr, ni;
      ubig_type   d, m;
      logic       ovf, dz;
      answer_type r;
      ar = q.a_re; ai = q.a_im; br = q.b_re; bi = q.b_im;
      re = '0; im = '0; ovf = 1'b0; dz = 1'b0;
      case (q.op)
         OP_ADD: begin
            re = ar + br; im = ai + bi;
         end
         OP_SUB: begin
            re = ar - br; im = ai - bi;
         end
         OP_MUL: begin
            re = product_round(ar * br - ai * bi);
            im = product_round(ar * bi + ai * br);
         end
         OP_DIV: begin
            d  = ubig_type'(br * br + bi * bi);
            nr = ar * br + ai * bi;
            ni = ai * br - ar * bi;
            dz = (d == 0);
            if (dz) begin
               re = zero_divide_limit(nr); im = zero_divide_limit(ni);
            end else begin
               re = quotient_round(nr, d); im = quotient_round(ni, d);
            end
         end
         OP_MAG: re = big_type'(magnitude(ar, ai));
         OP_SQRT: begin
            m  = magnitude(ar, ai);
            nr = big_type'(m) + ar;
            ni = big_type'(m) - ar;
            re = big_type'(half_round(int_sqrt(ubig_type'(nr < 0 ? -nr : nr) << (F + 1))));
            im = big_type'(half_round(int_sqrt(ubig_type'(ni < 0 ? -ni : ni) << (F + 1))));
            if (ai < 0) im = -im;
         end
         default: ;
      endcase
      r.re = clamp_word(re, ovf);
      r.im = clamp_word(im, ovf);
      r.st = dz ? ST_DZ : (ovf ? ST_OVF : ST_OK);
      return r;
   endfunction

   function automatic logic signed [W-1:0] pick_component();
      case ($urandom_range(0, 9))
         0: return MAXV;
         1: return MINV;
         2: return '0;
         3: return $signed($urandom_range(0, 8)) - 4;
         4, 5: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
         6: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic queue_request(op_type op, logic signed [W-1:0] are, logic signed [W-1:0] aim,
                                logic signed [W-1:0] bre, logic signed [W-1:0] bim);
      request_type q;
      q.op = op; q.a_re = are; q.a_im = aim; q.b_re = bre; q.b_im = bim;
      pending_requests.push_back(q);
   endtask

   initial begin
      request_type q;
      for (int o = 0; o < 8; o++) op_count[o] = 0;
      queue_request(OP_ADD, MAXV, MINV, MAXV, MINV);
      queue_request(OP_ADD, 32'sh0001_8000, -32'sh0000_4000, 32'sh0002_0000, 32'sh0000_0001);
      queue_request(OP_SUB, MINV, MAXV, MAXV, MINV);
      queue_request(OP_SUB, 32'sh0003_0000, 32'sh0001_0000, 32'sh0001_0000, 32'sh0004_0000);
      queue_request(OP_MUL, 32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, -32'sh0001_0000);
      queue_request(OP_MUL, MAXV, MAXV, MAXV, MINV);
      queue_request(OP_MUL, MINV, MINV, MINV, MINV);
      queue_request(OP_MUL, 32'sh0000_8000, 0, 32'sh0000_0001, 0);
      queue_request(OP_MUL, -32'sh0000_8000, 0, 32'sh0000_0001, 0);
      queue_request(OP_DIV, 32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 0);
      queue_request(OP_DIV, 32'sh0005_0000, -32'sh0003_0000, 0, 0);
      queue_request(OP_DIV, 0, 0, 0, 0);
      queue_request(OP_DIV, -32'sh0005_0000, 0, 0, 0);
      queue_request(OP_DIV, MAXV, MINV, 32'sh0000_0001, 0);
      queue_request(OP_DIV, 32'sh0001_0000, 0, 0, 32'sh0000_0003);
      queue_request(OP_MAG, 32'sh0003_0000, 32'sh0004_0000, 0, 0);
      queue_request(OP_MAG, MINV, MINV, MAXV, MAXV);
      queue_request(OP_MAG, 0, 0, 0, 0);
      queue_request(OP_SQRT, -32'sh0004_0000, 0, MAXV, MINV);
      queue_request(OP_SQRT, 32'sh0004_0000, 0, 0, 0);
      queue_request(OP_SQRT, 0, -32'sh0002_0000, 0, 0);
      queue_request(OP_SQRT, MINV, MINV, 0, 0);
      queue_request(OP_SQRT, MAXV, MAXV, 0, 0);
      queue_request(op_type'(6), MAXV, MINV, MAXV, MINV);
      queue_request(op_type'(7), 32'sh1234_5678, 1, 2, 3);
      for (int i = 0; i < 1030; i++) begin
         q.op   = ($urandom_range(0, 49) == 0) ? op_type'($urandom_range(6, 7))
                                               : op_type'($urandom_range(0, 5));
         q.a_re = pick_component();
         q.a_im = pick_component();
         q.b_re = ($urandom_range(0, 19) == 0) ? '0 : pick_component();
         q.b_im = ($urandom_range(0, 9) == 0) ? '0 : pick_component();
         pending_requests.push_back(q);
      end
   end

   // sender: bursts of random length with random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(negedge clock) begin
      request_type q;
      if (!reset && !(req_valid && !req_taken)) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
            stimulus_done = 1'b1;
         end else begin
            if (burst_left == 0) burst_left = $urandom_range(1, 40);
            q = pending_requests.pop_front();
            req_valid  <= 1'b1;
            req_opcode <= q.op;
            req_a_re   <= q.a_re;
            req_a_im   <= q.a_im;
            req_b_re   <= q.b_re;
            req_b_im   <= q.b_im;
            burst_left = burst_left - 1;
            if (burst_left == 0) gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
      end
   end

   // receiver: random stall pattern, free stretches, and one long hold-off
   int stall_phase = 0;
   int hold_cycles = 0;
   bit hold_done = 1'b0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (!hold_done && accepted_count >= 300) begin
         hold_cycles = hold_cycles + 1;
         rsp_ready <= 1'b0;
         if (hold_cycles >= 200) hold_done = 1'b1;
      end else begin
         stall_phase = (stall_phase + 1) % 256;
         if (stall_phase < 64) rsp_ready <= 1'b1;
         else if (stall_phase < 160) rsp_ready <= ($urandom_range(0, 3) != 0);
         else rsp_ready <= ($urandom_range(0, 2) == 0);
      end
   end

   always @(posedge clock) begin
      request_type q;
      answer_type  e;
      req_taken = req_valid && req_ready && !reset;
      if (req_taken) begin
         q.op = req_opcode; q.a_re = req_a_re; q.a_im = req_a_im;
         q.b_re = req_b_re; q.b_im = req_b_im;
         e = compute_complex(q);
         expected_answers.push_back(e);
         accepted_count = accepted_count + 1;
         op_count[q.op] = op_count[q.op] + 1;
         if (e.st == ST_DZ) dz_count = dz_count + 1;
         if (e.st == ST_OVF) ovf_count = ovf_count + 1;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         answer_count = answer_count + 1;
         if (expected_answers.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10) $display("unexpected response %0d", answer_count);
         end else begin
            e = expected_answers.pop_front();
            if (rsp_res_re !== e.re || rsp_res_im !== e.im || rsp_status !== e.st) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("response %0d: expected re %h im %h st %0d, got re %h im %h st %0d",
                           answer_count, e.re, e.im, e.st, rsp_res_re, rsp_res_im, rsp_status);
            end
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && !req_valid);
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      $display("%0d requests: add %0d sub %0d mul %0d div %0d mag %0d sqrt %0d other %0d",
               accepted_count, op_count[0], op_count[1], op_count[2], op_count[3],
               op_count[4], op_count[5], op_count[6] + op_count[7]);
      $display("divide by zero %0d, saturated %0d, mismatches %0d",
               dz_count, ovf_count, mismatch_count);
      if (mismatch_count == 0 && expected_answers.size() == 0)
         $display("PASS complex_arithmetic_unit");
      else
         $display("FAIL complex_arithmetic_unit");
      $finish;
   end

   initial begin
      #2ms;
      $display("FAIL complex_arithmetic_unit");
      $finish;
   end

endmodule
